@@ hw/rtl/pwsg_pkg.sv @@
package pwsg_pkg;

    // Waveform geometry and output range
    localparam int SAMPLES_PER_PERIOD = 100;
    localparam int FULL_SCALE         = 10000;
    localparam int DAC_MAX            = 65535;
    localparam int CENTRE             = FULL_SCALE / 2;
    localparam int HALF_PERIOD        = SAMPLES_PER_PERIOD / 2;
    localparam int QUARTER_PERIOD     = SAMPLES_PER_PERIOD / 4;
    localparam int SINE_DEN           = 2000;

    // Field widths
    localparam int IDX_W   = 7;
    localparam int CODE_W  = 16;
    localparam int AMP_W   = 14;
    localparam int OFF_W   = 14;
    localparam int SHAPE_W = 2;
    localparam int CFG_W   = 14;
    localparam int CFG_IDX_W = 2;

    // Constant dividers as multiply by reciprocal and shift.
    // amplitude / 100, exact for amplitude below 2**14
    localparam int STEP_RECIP = 5243;
    localparam int STEP_SHIFT = 19;
    // x / 125 after a shift by 4, i.e. y / 2000, exact for x below 2**24
    localparam int DIV_RECIP  = 8589935;
    localparam int DIV_SHIFT  = 30;
    localparam int DIV_PRE    = 4;
    // DAC_MAX / FULL_SCALE = 13107 / 2000
    localparam int SCALE_MUL  = 13107;
    // Largest sine numerator that still lands inside full scale
    localparam int SINE_SUM_MAX = FULL_SCALE * SINE_DEN;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd2;

    // Wave shape codes
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SAWTOOTH = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd3;

    // Reset value of the amplitude register
    localparam logic [AMP_W-1:0] AMP_RESET = 14'd1000;

    // One period of sine in signed thousandths
    localparam logic signed [10:0] SIN_MILLI [SAMPLES_PER_PERIOD] = '{
        11'sd0,    11'sd63,   11'sd127,  11'sd189,  11'sd251,
        11'sd312,  11'sd372,  11'sd430,  11'sd486,  11'sd540,
        11'sd593,  11'sd643,  11'sd690,  11'sd734,  11'sd776,
        11'sd814,  11'sd850,  11'sd881,  11'sd909,  11'sd934,
        11'sd955,  11'sd972,  11'sd985,  11'sd994,  11'sd999,
        11'sd1000, 11'sd997,  11'sd990,  11'sd979,  11'sd964,
        11'sd945,  11'sd923,  11'sd896,  11'sd866,  11'sd833,
        11'sd796,  11'sd756,  11'sd713,  11'sd667,  11'sd619,
        11'sd568,  11'sd514,  11'sd459,  11'sd402,  11'sd343,
        11'sd283,  11'sd221,  11'sd159,  11'sd96,   11'sd33,
        -11'sd31,  -11'sd94,  -11'sd157, -11'sd219, -11'sd281,
        -11'sd341, -11'sd400, -11'sd457, -11'sd513, -11'sd566,
        -11'sd617, -11'sd666, -11'sd712, -11'sd755, -11'sd795,
        -11'sd832, -11'sd865, -11'sd895, -11'sd922, -11'sd944,
        -11'sd963, -11'sd978, -11'sd990, -11'sd997, -11'sd1000,
        -11'sd999, -11'sd994, -11'sd985, -11'sd972, -11'sd955,
        -11'sd935, -11'sd910, -11'sd882, -11'sd851, -11'sd816,
        -11'sd777, -11'sd736, -11'sd692, -11'sd644, -11'sd595,
        -11'sd542, -11'sd488, -11'sd432, -11'sd374, -11'sd314,
        -11'sd253, -11'sd191, -11'sd129, -11'sd66,  -11'sd2
    };

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHAPE,
        ST_SUM,
        ST_SDIV,
        ST_SQUO,
        ST_MULK,
        ST_MULD,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/periodic_waveform_sample_generator_unit.sv @@
// Table-based waveform generator. Each transfer on the tick channel with
// i_tick high produces one DAC code for the current phase position of a
// 100-sample period and advances the phase, wrapping after sample 99; a
// transfer with i_tick low produces nothing and no stall. Shapes are
// sine (from a registered ROM of signed thousandths), triangle, falling
// sawtooth and square around a centre of 5000, with the offset setting
// negated and halved. The raw value is clipped to 0..10000 and scaled to
// 0..65535 with truncation. One item is in flight at a time: a tick with
// i_tick high stalls the tick channel through ST_LOAD to ST_DONE, sine
// adding ST_SUM, ST_SDIV and ST_SQUO. The single shared multiplier serves
// the sine product, both constant divisions by 2000 and the DAC scaling
// in separate states. The result sits in an output register, so a new
// tick is taken while it waits. Configuration is written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce.
module periodic_waveform_sample_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pwsg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwsg_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_tick_valid,
    output logic                              o_tick_stall,
    input  logic                              i_tick,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pwsg_pkg::CODE_W-1:0]       o_dac_code,
    output logic [pwsg_pkg::IDX_W-1:0]        o_sample_index
);
    import pwsg_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [SHAPE_W-1:0]       r_wave_shape;
    logic [AMP_W-1:0]         r_amplitude;
    logic signed [OFF_W-1:0]  r_offset;
    logic [IDX_W-1:0]         r_phase;

    logic [IDX_W-1:0]         r_idx;
    logic signed [10:0]       r_sin;
    logic [7:0]               r_step;
    logic [24:0]              r_acc;
    logic [AMP_W-1:0]         r_raw;
    logic signed [48:0]       r_prod;

    logic                     r_out_valid;
    logic [CODE_W-1:0]        r_dac_code;
    logic [IDX_W-1:0]         r_out_index;

    logic                     tick_xfer;
    logic                     out_free;
    logic                     is_sine;

    logic signed [14:0]       neg_off;
    logic signed [14:0]       neg_off_adj;
    logic signed [14:0]       cpo;
    logic [26:0]              step_prod;
    logic signed [8:0]        idx_s;
    logic signed [8:0]        coef;
    logic signed [17:0]       term;
    logic signed [17:0]       raw_s;
    logic [AMP_W-1:0]         raw_clip;
    logic signed [26:0]       cpo_scaled;
    logic signed [26:0]       sine_sum;
    logic [24:0]              sum_clip;

    logic signed [23:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [48:0]       mul_p;

    assign tick_xfer    = i_tick_valid && !o_tick_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign is_sine      = (r_wave_shape == SHAPE_SINE);
    assign o_tick_stall = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_dac_code   = r_dac_code;
    assign o_sample_index = r_out_index;

    // Centre plus offset, the offset negated and halved toward zero
    always_comb begin
        neg_off     = -15'(r_offset);
        neg_off_adj = neg_off + (neg_off[14] ? 15'sd1 : 15'sd0);
        cpo         = 15'(CENTRE) + (neg_off_adj >>> 1);
    end

    // Amplitude per sample step
    assign step_prod = 27'(r_amplitude) * 27'(STEP_RECIP);

    // Step multiplier for triangle and sawtooth
    always_comb begin
        idx_s = $signed({2'b00, r_idx});
        coef  = 9'(HALF_PERIOD) - idx_s;
        if (r_wave_shape == SHAPE_TRIANGLE) begin
            if (r_idx < IDX_W'(HALF_PERIOD)) begin
                coef = (idx_s <<< 1) - 9'(2 * QUARTER_PERIOD);
            end else begin
                coef = 9'(SAMPLES_PER_PERIOD + 2 * QUARTER_PERIOD) - (idx_s <<< 1);
            end
        end
        term = 18'($signed({1'b0, r_step})) * 18'(coef);
    end

    // Non-sine raw value and its clip to full scale
    always_comb begin
        if (r_wave_shape == SHAPE_SQUARE) begin
            if (r_idx < IDX_W'(HALF_PERIOD)) begin
                raw_s = 18'(cpo) + $signed({5'd0, r_amplitude[AMP_W-1:1]});
            end else begin
                raw_s = 18'(cpo) - $signed({5'd0, r_amplitude[AMP_W-1:1]});
            end
        end else begin
            raw_s = 18'(cpo) + term;
        end
        if (raw_s < 18'sd0) begin
            raw_clip = '0;
        end else if (raw_s > 18'(FULL_SCALE)) begin
            raw_clip = AMP_W'(FULL_SCALE);
        end else begin
            raw_clip = raw_s[AMP_W-1:0];
        end
    end

    // Sine numerator, clipped so that its quotient stays in full scale
    always_comb begin
        cpo_scaled = 27'(cpo) * 27'sd2000;
        sine_sum   = cpo_scaled + 27'(r_prod);
        if (sine_sum < 27'sd0) begin
            sum_clip = '0;
        end else if (sine_sum > 27'(SINE_SUM_MAX)) begin
            sum_clip = 25'(SINE_SUM_MAX);
        end else begin
            sum_clip = sine_sum[24:0];
        end
    end

    // Shared multiplier operands
    always_comb begin
        mul_a = 24'(r_raw);
        mul_b = 25'(SCALE_MUL);
        case (r_state)
            ST_SHAPE: begin
                mul_a = 24'(r_sin);
                mul_b = 25'(r_amplitude);
            end
            ST_SDIV: begin
                mul_a = 24'(r_acc[24:DIV_PRE]);
                mul_b = 25'(DIV_RECIP);
            end
            ST_MULD: begin
                mul_a = 24'(r_prod[26:DIV_PRE]);
                mul_b = 25'(DIV_RECIP);
            end
            default: begin
                mul_a = 24'(r_raw);
                mul_b = 25'(SCALE_MUL);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (tick_xfer && i_tick) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_SHAPE;
            ST_SHAPE: n_state = is_sine ? ST_SUM : ST_MULK;
            ST_SUM:   n_state = ST_SDIV;
            ST_SDIV:  n_state = ST_SQUO;
            ST_SQUO:  n_state = ST_MULK;
            ST_MULK:  n_state = ST_MULD;
            ST_MULD:  n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape <= SHAPE_SINE;
            r_amplitude  <= AMP_RESET;
            r_offset     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVE_SHAPE: r_wave_shape <= i_cfg_data[SHAPE_W-1:0];
                CFG_AMPLITUDE:  r_amplitude  <= i_cfg_data[AMP_W-1:0];
                CFG_OFFSET:     r_offset     <= $signed(i_cfg_data[OFF_W-1:0]);
                default: ;
            endcase
        end
    end

    // Phase: advance with wrap on a tick transfer with i_tick high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (tick_xfer && i_tick) begin
            if (r_phase >= IDX_W'(SAMPLES_PER_PERIOD - 1)) begin
                r_phase <= '0;
            end else begin
                r_phase <= r_phase + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (tick_xfer && i_tick) begin
                    r_idx <= r_phase;
                end
            end
            ST_LOAD: begin
                r_sin  <= SIN_MILLI[r_idx];
                r_step <= step_prod[STEP_SHIFT+7:STEP_SHIFT];
            end
            ST_SHAPE: begin
                if (is_sine) begin
                    r_prod <= mul_p;
                end else begin
                    r_raw <= raw_clip;
                end
            end
            ST_SUM: r_acc <= sum_clip;
            ST_SDIV: r_prod <= mul_p;
            ST_SQUO: r_raw <= r_prod[DIV_SHIFT+AMP_W-1:DIV_SHIFT];
            ST_MULK: r_prod <= mul_p;
            ST_MULD: r_prod <= mul_p;
            default: ;
        endcase
    end

    // Output register: load when free, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_dac_code  <= r_prod[DIV_SHIFT+CODE_W-1:DIV_SHIFT];
            r_out_index <= r_idx;
        end
    end

endmodule

@@ hw/rtl/pwsg_checker.sv @@
module pwsg_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pwsg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwsg_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_tick_valid,
    input  logic                              o_tick_stall,
    input  logic                              i_tick,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [pwsg_pkg::CODE_W-1:0]       o_dac_code,
    input  logic [pwsg_pkg::IDX_W-1:0]        o_sample_index
);
    import pwsg_pkg::*;

    // A tick that makes a sample occupies the generator on the next cycle
    a_busy_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick_valid && !o_tick_stall && i_tick |=> o_tick_stall)
        else $error("generator not busy after a sample tick");

    // A tick that makes no sample leaves the generator free
    a_free_after_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick_valid && !o_tick_stall && !i_tick |=> !o_tick_stall)
        else $error("generator busy after an empty tick");

    // A sample index always lies inside the period
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sample_index < IDX_W'(SAMPLES_PER_PERIOD))
        else $error("sample index outside the period");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_dac_code) && $stable(o_sample_index))
        else $error("stalled result changed");

endmodule

bind periodic_waveform_sample_generator_unit pwsg_checker u_pwsg_checker (.*);

@@ dv/tb_periodic_waveform_sample_generator_unit.sv @@
module tb_periodic_waveform_sample_generator_unit;
    import pwsg_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_TICKS   = 600;
    localparam int QUIET_TICKS    = 100;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One period of sine in signed thousandths
    localparam int SINE_MILLI [SAMPLES_PER_PERIOD] = '{
        0, 63, 127, 189, 251, 312, 372, 430, 486, 540,
        593, 643, 690, 734, 776, 814, 850, 881, 909, 934,
        955, 972, 985, 994, 999, 1000, 997, 990, 979, 964,
        945, 923, 896, 866, 833, 796, 756, 713, 667, 619,
        568, 514, 459, 402, 343, 283, 221, 159, 96, 33,
        -31, -94, -157, -219, -281, -341, -400, -457, -513, -566,
        -617, -666, -712, -755, -795, -832, -865, -895, -922, -944,
        -963, -978, -990, -997, -1000, -999, -994, -985, -972, -955,
        -935, -910, -882, -851, -816, -777, -736, -692, -644, -595,
        -542, -488, -432, -374, -314, -253, -191, -129, -66, -2
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  index;
    } t_dac_sample;

    // Tracks the waveform settings and phase, and holds the samples still owed
    class t_wave_sample_tracker;
        logic [SHAPE_W-1:0]      shape_reg;
        logic [AMP_W-1:0]        amp_reg;
        logic signed [OFF_W-1:0] offset_reg;
        int                      phase;
        int                      mismatches;
        t_dac_sample             expected_samples[$];

        function new();
            shape_reg  = SHAPE_SINE;
            amp_reg    = AMP_RESET;
            offset_reg = '0;
            phase      = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_WAVE_SHAPE: shape_reg = data[SHAPE_W-1:0];
                CFG_AMPLITUDE: amp_reg = data[AMP_W-1:0];
                CFG_OFFSET: offset_reg = data[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        // Build the clipped, scaled sample for the current phase
        function t_dac_sample sample_at_phase();
            int          k;
            int          amp_v;
            int          step;
            int          centre_off;
            longint      raw;
            t_dac_sample s;
            k          = phase;
            amp_v      = amp_reg;
            step       = amp_v / SAMPLES_PER_PERIOD;
            centre_off = CENTRE + (-int'(offset_reg)) / 2;
            case (shape_reg)
                SHAPE_SINE: begin
                    raw = (longint'(centre_off) * SINE_DEN
                           + longint'(SINE_MILLI[k]) * amp_v) / SINE_DEN;
                end
                SHAPE_TRIANGLE: begin
                    if (k < HALF_PERIOD)
                        raw = centre_off + step * (2 * (k - QUARTER_PERIOD));
                    else
                        raw = centre_off
                              + step * (SAMPLES_PER_PERIOD - 2 * (k - QUARTER_PERIOD));
                end
                SHAPE_SAWTOOTH: begin
                    raw = centre_off - (k - HALF_PERIOD) * step;
                end
                default: begin
                    if (k < HALF_PERIOD)
                        raw = centre_off + amp_v / 2;
                    else
                        raw = centre_off - amp_v / 2;
                end
            endcase
            if (raw > FULL_SCALE)
                raw = FULL_SCALE;
            else if (raw < 0)
                raw = 0;
            s.code  = CODE_W'((raw * DAC_MAX) / FULL_SCALE);
            s.index = IDX_W'(k);
            return s;
        endfunction

        // Note an accepted tick transfer; a low tick leaves the phase alone
        function void take_tick(bit level);
            if (!level)
                return;
            expected_samples.push_back(sample_at_phase());
            phase = (phase + 1 >= SAMPLES_PER_PERIOD) ? 0 : phase + 1;
        endfunction

        function void check_sample(logic [CODE_W-1:0] code, logic [IDX_W-1:0] index);
            t_dac_sample want;
            if (expected_samples.size() == 0) begin
                $error("unexpected sample: dac_code %0d sample_index %0d", code, index);
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            if (code !== want.code) begin
                $error("dac_code: expected %0d, actual %0d", want.code, code);
                mismatches++;
            end
            if (index !== want.index) begin
                $error("sample_index: expected %0d, actual %0d", want.index, index);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function bit all_matched();
            return (mismatches == 0) && (expected_samples.size() == 0);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_tick_valid;
    logic                 o_tick_stall;
    logic                 i_tick;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CODE_W-1:0]    o_dac_code;
    logic [IDX_W-1:0]     o_sample_index;

    t_wave_sample_tracker samples = new();
    bit                   quiet_tail   = 1'b0;
    bit                   hold_request = 1'b0;
    int                   idle_cycles  = 0;

    periodic_waveform_sample_generator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_tick_valid   (i_tick_valid),
        .o_tick_stall   (o_tick_stall),
        .i_tick         (i_tick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dac_code     (o_dac_code),
        .o_sample_index (o_sample_index)
    );

    always #2 i_clk = ~i_clk;

    // Check every sample transfer against the oldest owed sample
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            samples.check_sample(o_dac_code, o_sample_index);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_tick_valid && !o_tick_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stall the sample channel in random bursts, once for a long stretch
    initial begin : out_stall_driver
        int run;
        forever begin
            run = $urandom_range(1, 20);
            i_out_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_tail) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // Offer one tick, after an optional idle gap, and hold it until transfer
    task automatic send_tick(input bit level, input int gap);
        if (gap > 0) begin
            i_tick_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_tick_valid <= 1'b1;
        i_tick       <= level;
        @(posedge i_clk);
        while (o_tick_stall !== 1'b0) @(posedge i_clk);
        samples.take_tick(level);
    endtask

    // Drop valid and wait until every owed sample has come out
    task automatic settle();
        i_tick_valid <= 1'b0;
        while (samples.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        samples.set_reg(idx, data);
    endtask

    // Rewrite all settings while the block is idle
    task automatic configure(input logic [SHAPE_W-1:0] shape, input logic [CFG_W-1:0] amp,
                             input logic [CFG_W-1:0] off, input bit poke_unused);
        settle();
        write_reg(CFG_WAVE_SHAPE, CFG_W'(shape));
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_OFFSET, off);
        if (poke_unused)
            write_reg(CFG_UNUSED, '1);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_amp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(FULL_SCALE);
            2: return CFG_W'($urandom_range(0, 16383));
            default: return CFG_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_offset();
        case ($urandom_range(0, 9))
            0: return CFG_W'(-CENTRE);
            1: return CFG_W'(CENTRE);
            2: return CFG_W'($urandom_range(0, 16383));
            3: return CFG_W'(-8192);
            default: return CFG_W'(int'($urandom_range(0, FULL_SCALE)) - CENTRE);
        endcase
    endfunction

    initial begin : stimulus
        int ticks_sent;
        int phase_no;
        int burst;
        int gap;
        bit level;
        bit idle_on;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_WAVE_SHAPE;
        i_cfg_data   <= '0;
        i_tick_valid <= 1'b0;
        i_tick       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: sine, with low ticks mixed in
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);

        // Square, widest amplitude and most negative setting: clips high
        configure(SHAPE_SQUARE, '1, CFG_W'(-8192), 1'b1);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);

        // Triangle, full-scale amplitude, largest positive setting
        configure(SHAPE_TRIANGLE, CFG_W'(FULL_SCALE), CFG_W'(8191), 1'b0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);

        // Sawtooth with zero amplitude sits on the centre
        configure(SHAPE_SAWTOOTH, '0, '0, 1'b0);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);

        // Sine at the extremes of amplitude and offset
        configure(SHAPE_SINE, '1, CFG_W'(CENTRE), 1'b0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        configure(SHAPE_SINE, CFG_W'(FULL_SCALE), CFG_W'(-CENTRE), 1'b0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);

        // Random phases of random settings
        ticks_sent = 0;
        phase_no   = 0;
        while (ticks_sent < RANDOM_TICKS) begin
            if (ticks_sent >= RANDOM_TICKS - QUIET_TICKS)
                quiet_tail = 1'b1;
            configure(SHAPE_W'($urandom_range(0, 3)), random_amp(), random_offset(), 1'b0);
            idle_on = !quiet_tail && ($urandom_range(0, 2) != 0);
            if (phase_no == 2)
                hold_request = 1'b1;
            burst = $urandom_range(30, 80);
            repeat (burst) begin
                level = ($urandom_range(0, 7) != 0);
                gap   = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
                send_tick(level, gap);
                ticks_sent++;
            end
            phase_no++;
        end

        settle();
        if (samples.all_matched()) begin
            $display("*** PASSED ***");
        end else begin
            if (samples.pending() != 0)
                $error("%0d samples never arrived", samples.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
